// ----- src/lfps_pkg.sv -----
package lfps_pkg;

  localparam int SENSOR_COUNT       = 5;
  localparam int SAMPLE_BITS        = 10;
  localparam int POSITION_FRAC_BITS = 8;

  localparam int GAIN_BITS      = 12;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int SPEED_BITS     = 8;
  localparam int ECHO_BITS      = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam int CNT_BITS  = $clog2(SENSOR_COUNT);
  localparam int WT_BITS   = CNT_BITS + 2;
  localparam int HALF      = SENSOR_COUNT / 2;
  localparam int WS_BITS   = SAMPLE_BITS + $clog2(SENSOR_COUNT * HALF + 1) + 1;
  localparam int TOT_BITS  = SAMPLE_BITS + $clog2(SENSOR_COUNT + 1);
  localparam int MAG_BITS  = WS_BITS - 1;
  localparam int NUM_BITS  = MAG_BITS + POSITION_FRAC_BITS;
  localparam int POS_BITS  = $clog2(HALF) + POSITION_FRAC_BITS + 2;
  localparam int OPD_BITS  = POS_BITS + 1;
  localparam int PROD_BITS = GAIN_BITS + OPD_BITS;
  localparam int PD_BITS   = PROD_BITS + 1;
  localparam int PD_FRAC_BITS = GAIN_FRAC_BITS + POSITION_FRAC_BITS;
  localparam int V_BITS =
    ((PD_BITS > SPEED_BITS + PD_FRAC_BITS + 1) ? PD_BITS : SPEED_BITS + PD_FRAC_BITS + 1) + 1;

  localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RESET  = GAIN_BITS'(256);
  localparam logic [GAIN_BITS-1:0]  DERIV_GAIN_RESET = GAIN_BITS'(128);
  localparam logic [SPEED_BITS-1:0] BASE_SPEED_RESET = SPEED_BITS'(150);
  localparam logic [ECHO_BITS-1:0]  ECHO_LIMIT_RESET = ECHO_BITS'(589);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PROP_GAIN,
    REG_DERIV_GAIN,
    REG_BASE_SPEED,
    REG_ECHO_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [ECHO_BITS-1:0]   echo_time;
  } item_t;

  typedef struct packed {
    logic [SPEED_BITS-1:0] left_speed;
    logic [SPEED_BITS-1:0] right_speed;
    logic                  left_forward;
    logic                  right_forward;
    logic                  obstacle_stop;
  } result_t;

endpackage

// ----- src/line_follow_pd_steering.sv -----
// Line-following steering controller with PD correction and obstacle stop.
// The item channel (item_valid, item_stall, item) carries five line-sensor
// samples and a sonar echo time. The result channel (result_valid,
// result_stall, result) returns one beat per item with both wheel levels,
// the direction flags and the obstacle stop flag.
// Gains, base speed and the echo limit are set through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle,
// which the block itself does not enforce. An item passes through the
// summing of the SENSOR_COUNT samples, the bit-serial divider, the two
// bit-serial multipliers, the PD sum and the wheel step before its result
// is valid. A frame whose samples sum to zero skips the divider. One item
// is worked on at a time: the block takes no new beat until it is through
// with the last one, and item_stall is high while it works.
// A finished result waits in the output register while the next item is
// already taken and worked on; if it is still stalled when the next result
// is ready, the controller waits. Reset restores the register defaults and
// clears the previous error and the held direction flags.
module line_follow_pd_steering
  import lfps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  item_t                     item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV_START,
    S_DIV,
    S_MUL_START,
    S_MUL,
    S_PD,
    S_WHEEL
  } state_t;

  state_t state;

  logic [GAIN_BITS-1:0]  prop_gain;
  logic [GAIN_BITS-1:0]  deriv_gain;
  logic [SPEED_BITS-1:0] base_speed;
  logic [ECHO_BITS-1:0]  echo_limit;

  logic [SAMPLE_BITS-1:0]     samp [SENSOR_COUNT];
  logic [ECHO_BITS-1:0]       echo;
  logic [CNT_BITS-1:0]        cnt;
  logic signed [WS_BITS-1:0]  ws;
  logic [TOT_BITS-1:0]        tot;
  logic signed [POS_BITS-1:0] pos;
  logic signed [POS_BITS-1:0] last_error;
  logic [1:0]                 held_dir;
  logic signed [PD_BITS-1:0]  pd;

  logic signed [WT_BITS-1:0]   wt;
  logic signed [WS_BITS-1:0]   s_ext;
  logic signed [WS_BITS-1:0]   w_ext;
  logic signed [WS_BITS-1:0]   term;
  logic signed [WS_BITS-1:0]   ws_abs;
  logic [NUM_BITS-1:0]         dividend;
  logic [POS_BITS-1:0]         q_low;
  logic signed [POS_BITS-1:0]  pos_div;
  logic signed [OPD_BITS-1:0]  pos_ext;
  logic signed [OPD_BITS-1:0]  err_diff;
  logic signed [V_BITS-1:0]    base_scaled;
  logic signed [V_BITS-1:0]    pd_ext;
  logic [SPEED_BITS-1:0]       left_lvl;
  logic [SPEED_BITS-1:0]       right_lvl;
  logic                        stop;

  logic                        div_start;
  logic                        div_done;
  logic [NUM_BITS-1:0]         quotient;
  logic                        mul_start;
  logic                        p_done;
  logic                        d_done;
  logic signed [PROD_BITS-1:0] p_prod;
  logic signed [PROD_BITS-1:0] d_prod;

  function automatic logic [SPEED_BITS-1:0] wheel_level(input logic signed [V_BITS-1:0] v);
    logic [V_BITS-PD_FRAC_BITS-1:0] whole;
    logic [SPEED_BITS-1:0]          lvl;
    whole = v[V_BITS-1:PD_FRAC_BITS];
    if (v[V_BITS-1] || (v == '0)) begin
      lvl = '0;
    end else if (|whole[V_BITS-PD_FRAC_BITS-1:SPEED_BITS]) begin
      lvl = '1;
    end else begin
      lvl = whole[SPEED_BITS-1:0];
    end
    return lvl;
  endfunction

  always_comb begin
    wt    = $signed({2'b00, cnt}) - WT_BITS'((SENSOR_COUNT - 1) / 2);
    s_ext = {{(WS_BITS-SAMPLE_BITS){1'b0}}, samp[0]};
    w_ext = {{(WS_BITS-WT_BITS){wt[WT_BITS-1]}}, wt};
    term  = s_ext * w_ext;

    ws_abs   = ws[WS_BITS-1] ? -ws : ws;
    dividend = {ws_abs[MAG_BITS-1:0], {POSITION_FRAC_BITS{1'b0}}};
    q_low    = quotient[POS_BITS-1:0];
    pos_div  = ws[WS_BITS-1] ? -$signed(q_low) : $signed(q_low);

    pos_ext  = {pos[POS_BITS-1], pos};
    err_diff = pos_ext - {last_error[POS_BITS-1], last_error};

    base_scaled = $signed({{(V_BITS-SPEED_BITS-PD_FRAC_BITS){1'b0}}, base_speed,
                           {PD_FRAC_BITS{1'b0}}});
    pd_ext      = {{(V_BITS-PD_BITS){pd[PD_BITS-1]}}, pd};
    left_lvl    = wheel_level(base_scaled - pd_ext);
    right_lvl   = wheel_level(base_scaled + pd_ext);
    stop        = (echo < echo_limit);
  end

  assign item_stall = (state != S_IDLE);
  assign div_start  = (state == S_DIV_START) && (tot != '0);
  assign mul_start  = (state == S_MUL_START);

  lfps_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (tot),
    .done     (div_done),
    .quotient (quotient)
  );

  lfps_sermul u_mul_p (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .gain    (prop_gain),
    .operand (pos_ext),
    .done    (p_done),
    .product (p_prod)
  );

  lfps_sermul u_mul_d (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .gain    (deriv_gain),
    .operand (err_diff),
    .done    (d_done),
    .product (d_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      last_error   <= '0;
      held_dir     <= '0;
      prop_gain    <= PROP_GAIN_RESET;
      deriv_gain   <= DERIV_GAIN_RESET;
      base_speed   <= BASE_SPEED_RESET;
      echo_limit   <= ECHO_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain  <= cfg_data[GAIN_BITS-1:0];
          REG_DERIV_GAIN: deriv_gain <= cfg_data[GAIN_BITS-1:0];
          REG_BASE_SPEED: base_speed <= cfg_data[SPEED_BITS-1:0];
          REG_ECHO_LIMIT: echo_limit <= cfg_data[ECHO_BITS-1:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall && (state != S_WHEEL)) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            samp[0] <= item.sample_0;
            samp[1] <= item.sample_1;
            samp[2] <= item.sample_2;
            samp[3] <= item.sample_3;
            samp[4] <= item.sample_4;
            echo    <= item.echo_time;
            cnt     <= '0;
            ws      <= '0;
            tot     <= '0;
            state   <= S_SUM;
          end
        end
        S_SUM: begin
          ws  <= ws + term;
          tot <= tot + {{(TOT_BITS-SAMPLE_BITS){1'b0}}, samp[0]};
          for (int i = 0; i < SENSOR_COUNT - 1; i++) begin
            samp[i] <= samp[i+1];
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BITS'(SENSOR_COUNT - 1)) begin
            state <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          if (tot == '0) begin
            pos   <= '0;
            state <= S_MUL_START;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pos   <= pos_div;
            state <= S_MUL_START;
          end
        end
        S_MUL_START: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (p_done && d_done) begin
            state <= S_PD;
          end
        end
        S_PD: begin
          pd    <= {p_prod[PROD_BITS-1], p_prod} + {d_prod[PROD_BITS-1], d_prod};
          state <= S_WHEEL;
        end
        S_WHEEL: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            last_error   <= pos;
            if (stop) begin
              result.left_speed    <= '0;
              result.right_speed   <= '0;
              result.left_forward  <= held_dir[0];
              result.right_forward <= held_dir[1];
              result.obstacle_stop <= 1'b1;
            end else begin
              result.left_speed    <= left_lvl;
              result.right_speed   <= right_lvl;
              result.left_forward  <= (left_lvl != '0);
              result.right_forward <= (right_lvl != '0);
              result.obstacle_stop <= 1'b0;
              held_dir             <= {(right_lvl != '0), (left_lvl != '0)};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/lfps_serdiv.sv -----
module lfps_serdiv
  import lfps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [TOT_BITS-1:0] divisor,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int DCNT_BITS = $clog2(NUM_BITS + 1);

  logic                 busy;
  logic [DCNT_BITS-1:0] cnt;
  logic [TOT_BITS-1:0]  rem;
  logic [TOT_BITS-1:0]  den;
  logic [NUM_BITS-1:0]  num;

  logic [TOT_BITS:0]   shifted;
  logic [TOT_BITS:0]   diff;
  logic                qbit;
  logic [TOT_BITS-1:0] rem_next;

  // One quotient bit per cycle; quotient bits shift in behind the dividend.
  always_comb begin
    shifted  = {rem, num[NUM_BITS-1]};
    diff     = shifted - {1'b0, den};
    qbit     = (shifted >= {1'b0, den});
    rem_next = qbit ? diff[TOT_BITS-1:0] : shifted[TOT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num  <= dividend;
        den  <= divisor;
        rem  <= '0;
        cnt  <= DCNT_BITS'(NUM_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        num <= {num[NUM_BITS-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = num;

endmodule

// ----- src/lfps_sermul.sv -----
module lfps_sermul
  import lfps_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [GAIN_BITS-1:0]        gain,
  input  logic signed [OPD_BITS-1:0]  operand,
  output logic                        done,
  output logic signed [PROD_BITS-1:0] product
);

  localparam int MCNT_BITS = $clog2(GAIN_BITS + 1);

  logic                        busy;
  logic [MCNT_BITS-1:0]        cnt;
  logic [GAIN_BITS-1:0]        g;
  logic signed [OPD_BITS-1:0]  op;
  logic signed [PROD_BITS-1:0] acc;

  logic signed [PROD_BITS-1:0] op_ext;
  logic signed [PROD_BITS-1:0] acc_next;

  // Gain bits are taken most significant first, one per cycle.
  always_comb begin
    op_ext   = {{(PROD_BITS-OPD_BITS){op[OPD_BITS-1]}}, op};
    acc_next = {acc[PROD_BITS-2:0], 1'b0} + (g[GAIN_BITS-1] ? op_ext : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        g    <= gain;
        op   <= operand;
        acc  <= '0;
        cnt  <= MCNT_BITS'(GAIN_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc_next;
        g   <= {g[GAIN_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == MCNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

// ----- src/lfps_checker.sv -----
module lfps_checker
  import lfps_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result beat stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed or was dropped");

  // The controller works on one item at a time after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item channel not stalled after an accepted beat");

  // An obstacle stop drives both wheels to zero.
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.obstacle_stop |->
      (result.left_speed == '0) && (result.right_speed == '0))
    else $error("wheel level nonzero during obstacle stop");

  // Without a stop, each direction flag tracks whether its wheel turns.
  a_dir_match: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.obstacle_stop |->
      (result.left_forward == (result.left_speed != '0)) &&
      (result.right_forward == (result.right_speed != '0)))
    else $error("direction flag does not match wheel level");

endmodule

bind line_follow_pd_steering lfps_checker u_checker (.*);

// ----- verif/tb_line_follow_pd_steering.sv -----
module tb_line_follow_pd_steering;
  import lfps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int FRAMES_PER_PHASE = 150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 100;

  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    item_t                    frame;
    cfg_reg_t                 reg_sel;
    logic [CFG_DATA_BITS-1:0] reg_data;
    bit                       known;
    result_t                  want;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      item_valid;
  logic                      item_stall;
  item_t                     item;
  logic                      result_valid;
  logic                      result_stall;
  result_t                   result;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  logic [GAIN_BITS-1:0]        prop_q;
  logic [GAIN_BITS-1:0]        deriv_q;
  logic [SPEED_BITS-1:0]       base_q;
  logic [ECHO_BITS-1:0]        limit_q;
  logic signed [POS_BITS-1:0]  last_pos;
  logic [1:0]                  held_fwd;

  result_t   wheel_q [$];
  plan_row_t plan [$];

  int errors;
  int beats_checked;
  int frames_sent;
  int stops_seen;
  int settings_used;
  int cycles;
  int hold_left;
  bit steady;

  line_follow_pd_steering i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SPEED_BITS-1:0] wheel_drive(longint level_fx);
    longint whole;
    if (level_fx <= 0) begin
      return '0;
    end
    whole = level_fx >>> PD_FRAC_BITS;
    if (whole > 255) begin
      whole = 255;
    end
    return whole[SPEED_BITS-1:0];
  endfunction

  // Predicts one frame's result and advances the tracked error and direction state.
  function automatic result_t steer_predict(item_t frame);
    longint lvl [SENSOR_COUNT];
    longint weighted;
    longint total;
    longint pos;
    longint pd;
    longint base_fx;
    result_t r;
    int i;
    lvl[0] = frame.sample_0;
    lvl[1] = frame.sample_1;
    lvl[2] = frame.sample_2;
    lvl[3] = frame.sample_3;
    lvl[4] = frame.sample_4;
    weighted = 0;
    total = 0;
    pos = 0;
    for (i = 0; i < SENSOR_COUNT; i++) begin
      weighted += lvl[i] * (i - HALF);
      total += lvl[i];
    end
    if (total > 0) begin
      pos = (weighted * (longint'(1) << POSITION_FRAC_BITS)) / total;
    end
    pd = longint'(prop_q) * pos + longint'(deriv_q) * (pos - longint'(last_pos));
    last_pos = pos[POS_BITS-1:0];
    r = '0;
    if (frame.echo_time < limit_q) begin
      r.obstacle_stop = 1'b1;
    end else begin
      base_fx = longint'(base_q) << PD_FRAC_BITS;
      r.left_speed = wheel_drive(base_fx - pd);
      r.right_speed = wheel_drive(base_fx + pd);
      held_fwd = {r.right_speed != 0, r.left_speed != 0};
    end
    r.left_forward = held_fwd[0];
    r.right_forward = held_fwd[1];
    return r;
  endfunction

  function automatic item_t frame_of(logic [SAMPLE_BITS-1:0] s0, logic [SAMPLE_BITS-1:0] s1,
                                     logic [SAMPLE_BITS-1:0] s2, logic [SAMPLE_BITS-1:0] s3,
                                     logic [SAMPLE_BITS-1:0] s4, logic [ECHO_BITS-1:0] echo);
    item_t f;
    f.sample_0 = s0;
    f.sample_1 = s1;
    f.sample_2 = s2;
    f.sample_3 = s3;
    f.sample_4 = s4;
    f.echo_time = echo;
    return f;
  endfunction

  function automatic plan_row_t frame_row(item_t f, bit known, result_t want);
    plan_row_t r;
    r.kind = ROW_FRAME;
    r.frame = f;
    r.reg_sel = REG_PROP_GAIN;
    r.reg_data = '0;
    r.known = known;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t write_row(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] data);
    plan_row_t r;
    r.kind = ROW_WRITE;
    r.frame = '0;
    r.reg_sel = sel;
    r.reg_data = data;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic item_t random_frame();
    logic [SAMPLE_BITS-1:0] s [SENSOR_COUNT];
    logic [ECHO_BITS-1:0]   echo;
    logic [95:0]            noise;
    item_t                  f;
    int                     pick;
    int                     centre;
    int                     gap;
    int                     i;
    pick = $urandom_range(0, 99);
    centre = $urandom_range(0, SENSOR_COUNT - 1);
    noise = {$urandom, $urandom, $urandom};
    for (i = 0; i < SENSOR_COUNT; i++) begin
      gap = (i > centre) ? i - centre : centre - i;
      if (pick < 60) begin
        if (gap == 0) begin
          s[i] = SAMPLE_BITS'($urandom_range(600, 1023));
        end else if (gap == 1) begin
          s[i] = SAMPLE_BITS'($urandom_range(0, 600));
        end else begin
          s[i] = SAMPLE_BITS'($urandom_range(0, 150));
        end
      end else if (pick < 70) begin
        s[i] = '0;
      end else if (pick < 80) begin
        s[i] = (gap == 0) ? SAMPLE_BITS'($urandom) : '0;
      end else begin
        s[i] = noise[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    case ($urandom_range(0, 9))
      0, 1, 2: echo = (limit_q == 0) ? '0 : ECHO_BITS'($urandom_range(0, limit_q - 1));
      3:       echo = limit_q;
      4:       echo = '1;
      5:       echo = '0;
      default: echo = ECHO_BITS'($urandom);
    endcase
    f = frame_of(s[0], s[1], s[2], s[3], s[4], echo);
    return f;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (errors < 40) begin
      $display("mismatch on beat %0d: %s is %0d, expected %0d", beats_checked, what, got, want);
    end
    errors++;
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    @(posedge clk);
    case (sel)
      REG_PROP_GAIN:  prop_q = data[GAIN_BITS-1:0];
      REG_DERIV_GAIN: deriv_q = data[GAIN_BITS-1:0];
      REG_BASE_SPEED: base_q = data[SPEED_BITS-1:0];
      REG_ECHO_LIMIT: limit_q = data[ECHO_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer_item(item_t frame, bit known, result_t want);
    result_t pred;
    logic [95:0] junk;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 17) begin
      junk = {$urandom, $urandom, $urandom};
      item_valid <= 1'b0;
      item <= junk[$bits(item_t)-1:0];
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= frame;
    do begin
      @(posedge clk);
    end while (item_stall);
    pred = steer_predict(frame);
    wheel_q.push_back(known ? want : pred);
    frames_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (wheel_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The sink stalls at random unless steady, or for a counted hold-off when one is requested.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(0, 99) < 17);
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (wheel_q.size() == 0) begin
        flag_mismatch("unexpected beat", 1, 0);
      end else begin
        exp_r = wheel_q.pop_front();
        if (result.left_speed !== exp_r.left_speed)
          flag_mismatch("left_speed", result.left_speed, exp_r.left_speed);
        if (result.right_speed !== exp_r.right_speed)
          flag_mismatch("right_speed", result.right_speed, exp_r.right_speed);
        if (result.left_forward !== exp_r.left_forward)
          flag_mismatch("left_forward", result.left_forward, exp_r.left_forward);
        if (result.right_forward !== exp_r.right_forward)
          flag_mismatch("right_forward", result.right_forward, exp_r.right_forward);
        if (result.obstacle_stop !== exp_r.obstacle_stop)
          flag_mismatch("obstacle_stop", result.obstacle_stop, exp_r.obstacle_stop);
        if (exp_r.obstacle_stop) begin
          stops_seen++;
        end
      end
      beats_checked++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int ph;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PROP_GAIN;
    cfg_data = '0;
    prop_q = PROP_GAIN_RESET;
    deriv_q = DERIV_GAIN_RESET;
    base_q = BASE_SPEED_RESET;
    limit_q = ECHO_LIMIT_RESET;
    last_pos = '0;
    held_fwd = '0;
    errors = 0;
    beats_checked = 0;
    frames_sent = 0;
    stops_seen = 0;
    settings_used = 1;
    cycles = 0;
    hold_left = 0;
    steady = 1'b0;

    plan.push_back(frame_row(frame_of(0, 0, 0, 0, 0, 16'h0000), 1'b1,
                             result_t'{8'd0, 8'd0, 1'b0, 1'b0, 1'b1}));
    plan.push_back(frame_row(frame_of(0, 0, 0, 0, 0, 16'hFFFF), 1'b1,
                             result_t'{8'd150, 8'd150, 1'b1, 1'b1, 1'b0}));
    plan.push_back(frame_row(frame_of(0, 0, 0, 0, 0, 16'd588), 1'b1,
                             result_t'{8'd0, 8'd0, 1'b1, 1'b1, 1'b1}));
    plan.push_back(frame_row(frame_of(0, 0, 0, 0, 0, 16'd589), 1'b1,
                             result_t'{8'd150, 8'd150, 1'b1, 1'b1, 1'b0}));
    plan.push_back(frame_row(frame_of(1023, 0, 0, 0, 0, 16'hFFFF), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 0, 0, 0, 1023, 16'hFFFF), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 1023, 0, 0, 0, 16'hFFFF), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 0, 0, 1023, 0, 16'hFFFF), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 0, 1023, 0, 0, 16'hFFFF), 1'b0, '0));
    plan.push_back(frame_row(frame_of(1023, 1023, 1023, 1023, 1023, 16'hFFFF), 1'b0, '0));
    plan.push_back(frame_row(frame_of(1, 0, 2, 0, 0, 16'd600), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 0, 2, 0, 1, 16'd600), 1'b0, '0));
    plan.push_back(frame_row(frame_of(10'h155, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 16'hAAAA),
                             1'b0, '0));
    plan.push_back(write_row(REG_PROP_GAIN, 16'hFFFF));
    plan.push_back(write_row(REG_DERIV_GAIN, 16'hFFFF));
    plan.push_back(write_row(REG_BASE_SPEED, 16'hFFFF));
    plan.push_back(frame_row(frame_of(1023, 0, 0, 0, 0, 16'h5555), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 0, 0, 0, 1023, 16'h5555), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 0, 1023, 0, 0, 16'h5555), 1'b0, '0));
    plan.push_back(write_row(REG_ECHO_LIMIT, 16'hFFFF));
    plan.push_back(frame_row(frame_of(0, 1023, 0, 0, 0, 16'hFFFE), 1'b0, '0));
    plan.push_back(frame_row(frame_of(0, 0, 0, 1023, 0, 16'hFFFF), 1'b0, '0));
    plan.push_back(write_row(REG_PROP_GAIN, 16'h0000));
    plan.push_back(write_row(REG_DERIV_GAIN, 16'h0000));
    plan.push_back(write_row(REG_ECHO_LIMIT, 16'h0000));
    plan.push_back(frame_row(frame_of(1023, 0, 0, 0, 0, 16'h0000), 1'b1,
                             result_t'{8'd255, 8'd255, 1'b1, 1'b1, 1'b0}));
    plan.push_back(write_row(REG_BASE_SPEED, 16'h0000));
    plan.push_back(frame_row(frame_of(1023, 1023, 1023, 1023, 1023, 16'h0000), 1'b1,
                             result_t'{8'd0, 8'd0, 1'b0, 1'b0, 1'b0}));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[n].reg_sel, plan[n].reg_data);
        settings_used++;
      end else begin
        offer_item(plan[n].frame, plan[n].known, plan[n].want);
      end
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(REG_PROP_GAIN, 16'(PROP_GAIN_RESET));
          write_reg(REG_DERIV_GAIN, 16'(DERIV_GAIN_RESET));
          write_reg(REG_BASE_SPEED, 16'(BASE_SPEED_RESET));
          write_reg(REG_ECHO_LIMIT, 16'(ECHO_LIMIT_RESET));
        end
        1: begin
          write_reg(REG_PROP_GAIN, 16'h0FFF);
          write_reg(REG_DERIV_GAIN, 16'h0FFF);
          write_reg(REG_BASE_SPEED, 16'h00FF);
          write_reg(REG_ECHO_LIMIT, 16'($urandom_range(300, 3000)));
        end
        2: begin
          write_reg(REG_PROP_GAIN, 16'h0000);
          write_reg(REG_DERIV_GAIN, 16'($urandom));
          write_reg(REG_BASE_SPEED, 16'($urandom));
          write_reg(REG_ECHO_LIMIT, 16'h0000);
        end
        default: begin
          write_reg(REG_PROP_GAIN, 16'($urandom));
          write_reg(REG_DERIV_GAIN, 16'($urandom_range(0, 1023)));
          write_reg(REG_BASE_SPEED, 16'($urandom));
          write_reg(REG_ECHO_LIMIT, 16'($urandom_range(0, 4000)));
        end
      endcase
      settings_used++;
      @(posedge clk);
      if (ph == 3) begin
        hold_left = HOLD_OFF_CYCLES;
      end
      steady = (ph == 4);
      repeat (FRAMES_PER_PHASE) offer_item(random_frame(), 1'b0, '0);
    end

    drain_results();
    steady = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (wheel_q.size() != 0) begin
      flag_mismatch("beats still pending", 0, wheel_q.size());
    end

    $display("Sent %0d sensor frames under %0d register settings; %0d beats checked.",
             frames_sent, settings_used, beats_checked);
    $display("Of those beats %0d were obstacle stops; %0d mismatches.", stops_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lfps_pkg.sv
src/lfps_serdiv.sv
src/lfps_sermul.sv
src/line_follow_pd_steering.sv
src/lfps_checker.sv
verif/tb_line_follow_pd_steering.sv
